[sv/sliding_window_maximum_assert.svh]
// Assertion macros for the sliding window maximum RTL.
// SWM_ASSERT checks a condition at every rising clock edge outside reset.
// SWM_ASSERT_IMP checks an implication at every rising clock edge outside reset.
`ifndef SLIDING_WINDOW_MAXIMUM_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_ASSERT_SVH

`ifndef SYNTHESIS

`define SWM_ASSERT(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("sliding window maximum: check failed");

`define SWM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sliding window maximum: check failed");

`else

`define SWM_ASSERT(label, cond)

`define SWM_ASSERT_IMP(label, ante, cons)

`endif

`endif

[sv/swm_pkg.sv]
`timescale 1ns / 1ps

package swm_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 32;
    localparam int CFG_BITS    = 7;
    localparam int WIN_BITS    = $clog2(MAX_WINDOW + 1);

    // 4-ary select tree over the cells
    localparam int TREE_RAW    = ($clog2(MAX_WINDOW) + 1) / 2;
    localparam int TREE_LEVELS = (TREE_RAW < 1) ? 1 : TREE_RAW;
    localparam int LEAVES      = 1 << (2 * TREE_LEVELS);
    localparam int INTERNAL    = (LEAVES - 1) / 3;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic    vld;
        t_sample value;
    } t_cand;

    typedef struct packed {
        logic    shift;
        logic    clear;
        t_sample sample;
    } t_cell_ctl;

endpackage

[sv/swm_cell.sv]
`timescale 1ns / 1ps

module swm_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swm_pkg::t_cell_ctl i_ctl,
    input  logic               i_fresh,
    input  logic               i_live,
    input  swm_pkg::t_cand     i_prev,
    output swm_pkg::t_cand     o_cand
);
    import swm_pkg::*;

    logic    r_vld;
    t_sample r_value;
    logic    n_vld;

    // keep the neighbor's candidate if it is still inside the window and beats the new sample
    always_comb begin
        n_vld = i_prev.vld && (i_fresh || (!i_ctl.clear && i_live &&
                (i_prev.value > i_ctl.sample)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.shift) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_value <= i_prev.value;
        end
    end

    assign o_cand = '{vld: r_vld, value: r_value};

endmodule

[sv/swm_pick.sv]
`timescale 1ns / 1ps

module swm_pick (
    input  logic           i_clk,
    input  logic           i_en,
    input  swm_pkg::t_cand i_kids [4],
    output swm_pkg::t_cand o_node
);
    import swm_pkg::*;

    t_cand r_node;
    t_cand n_node;

    // the oldest valid candidate is the front of the deque: take the highest valid child
    always_comb begin
        if (i_kids[3].vld) begin
            n_node = i_kids[3];
        end else if (i_kids[2].vld) begin
            n_node = i_kids[2];
        end else if (i_kids[1].vld) begin
            n_node = i_kids[1];
        end else begin
            n_node = i_kids[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_node <= n_node;
        end
    end

    assign o_node = r_node;

endmodule

[sv/sliding_window_maximum.sv]
`timescale 1ns / 1ps

// Sliding window maximum over a stream of signed samples. A row of MAX_WINDOW cells
// holds the candidate deque by age: cell j holds the sample that arrived j transfers
// ago, so each transfer shifts the row by one and every cell decides on its own whether
// its candidate survives (still inside the window and greater than the new sample).
// The front of the deque is the oldest surviving candidate, found by a registered
// 4-way select tree with TREE_LEVELS levels (3 for 64 cells). One sample is taken in
// every cycle while results are taken; a sample is registered in the cell row and
// then in each level of the select tree, its result flag alongside, and its result
// can be taken in the cycle that it goes valid. No result comes until window_size
// samples of the current sequence have arrived. A window register of zero acts as
// one, and values above MAX_WINDOW act as MAX_WINDOW. Write the window register only
// while the block is idle; a write keeps the current sequence.
module sliding_window_maximum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [swm_pkg::CFG_BITS-1:0]        i_cfg_window_size,
    // samples
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [swm_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                i_start_req,
    // results
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [swm_pkg::SAMPLE_BITS-1:0] o_window_max
);
    import swm_pkg::*;

`include "sliding_window_maximum_assert.svh"

    logic [CFG_BITS-1:0]    r_cfg;
    logic [WIN_BITS-1:0]    w_eff;
    logic [WIN_BITS-1:0]    r_seen;
    logic [WIN_BITS-1:0]    n_seen;
    logic [WIN_BITS-1:0]    w_seen_base;
    logic [WIN_BITS-1:0]    w_seen_sat;
    logic                   w_adv;
    logic                   w_take;
    logic                   w_emit;
    logic [TREE_LEVELS:0]   r_emit;
    t_cell_ctl              w_ctl;
    t_cand                  w_head_in;
    t_cand                  w_cell [MAX_WINDOW];
    t_cand                  w_leaf [LEAVES];
    t_cand                  w_node [INTERNAL];

    // configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_BITS'(1);
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_window_size;
        end
    end

    // clamp the window to 1..MAX_WINDOW
    always_comb begin
        if (r_cfg == '0) begin
            w_eff = WIN_BITS'(1);
        end else if (int'(r_cfg) > MAX_WINDOW) begin
            w_eff = WIN_BITS'(MAX_WINDOW);
        end else begin
            w_eff = WIN_BITS'(r_cfg);
        end
    end

    // advance the whole pipeline unless a result waits at the output
    assign w_adv      = !r_emit[TREE_LEVELS] || i_out_ready;
    assign o_in_ready = w_adv;
    assign w_take     = i_in_valid && w_adv;

    // samples seen in this sequence, clamped to the window and saturating there
    always_comb begin
        w_seen_base = i_start_req ? '0 : r_seen;
        w_seen_sat  = (w_seen_base > w_eff) ? w_eff : w_seen_base;
        n_seen      = (w_seen_sat < w_eff) ? w_seen_sat + 1'b1 : w_seen_sat;
        w_emit      = (n_seen >= w_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (w_take) begin
            r_seen <= n_seen;
        end
    end

    // cell row: the new sample enters cell 0, older candidates move one cell per transfer
    assign w_ctl     = '{shift: w_take, clear: i_start_req, sample: i_sample};
    assign w_head_in = '{vld: 1'b1, value: i_sample};

    for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
        if (j == 0) begin : g_head
            swm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_fresh (1'b1),
                .i_live  (1'b1),
                .i_prev  (w_head_in),
                .o_cand  (w_cell[j])
            );
        end else begin : g_body
            // the candidate in cell j-1 is j samples old once the new sample arrives
            swm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_fresh (1'b0),
                .i_live  (WIN_BITS'(j) < w_eff),
                .i_prev  (w_cell[j-1]),
                .o_cand  (w_cell[j])
            );
        end
    end

    // pad the tree leaves with empty candidates
    for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
        if (k < MAX_WINDOW) begin : g_real
            assign w_leaf[k] = w_cell[k];
        end else begin : g_pad
            assign w_leaf[k] = '{vld: 1'b0, value: '0};
        end
    end

    // registered 4-way select tree, heap order: node k has children 4k+1 .. 4k+4
    for (genvar k = 0; k < INTERNAL; k++) begin : g_node
        t_cand w_kids [4];
        for (genvar m = 0; m < 4; m++) begin : g_kid
            if (4 * k + 1 + m < INTERNAL) begin : g_int
                assign w_kids[m] = w_node[4 * k + 1 + m];
            end else begin : g_ext
                assign w_kids[m] = w_leaf[4 * k + 1 + m - INTERNAL];
            end
        end
        swm_pick u_pick (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_kids (w_kids),
            .o_node (w_node[k])
        );
    end

    // result flags travel alongside the tree levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= '0;
        end else if (w_adv) begin
            r_emit <= {r_emit[TREE_LEVELS-1:0], w_take && w_emit};
        end
    end

    assign o_out_valid  = r_emit[TREE_LEVELS];
    assign o_window_max = w_node[0].value;

    `SWM_ASSERT_IMP(a_head_filled, r_emit[0], w_cell[0].vld)
    `SWM_ASSERT_IMP(a_cells_fall, w_cell[0].vld && w_cell[1].vld,
        w_cell[1].value > w_cell[0].value)
    `SWM_ASSERT(a_seen_bound, int'(r_seen) <= MAX_WINDOW)
    `SWM_ASSERT_IMP(a_root_valid, o_out_valid, w_node[0].vld)
    `SWM_ASSERT_IMP(a_emit_from_take, $rose(r_emit[0]), $past(i_in_valid && o_in_ready))

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

// Checks sliding_window_maximum against a queue-based deque model kept in the bench.
// A short directed table comes first, then random phases. Each phase writes the window
// register while the block is idle and then sends one to four sample sequences.
module tb_top;
    import swm_pkg::*;

    localparam int POS_BITS = $clog2(2 * MAX_WINDOW);
    localparam int DIR_N    = 25;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // One row of the directed table. A ROW_CFG row carries the window value in data.
    // When known is set, known_max is the result that the row must give.
    typedef struct packed {
        t_row_kind   kind;
        logic [31:0] data;
        logic        start;
        logic        known;
        logic [31:0] known_max;
    } t_dir_row;

    // One kept candidate: its value and the position at which it arrived
    typedef struct {
        t_sample             value;
        logic [POS_BITS-1:0] pos;
    } t_model_cand;

    // Window shrinks and grows, saturation, equal samples and restarts.
    // Directed results are typed in only where they can be read off directly.
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        '{ROW_ITEM, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
        '{ROW_ITEM, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000},
        '{ROW_ITEM, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF},
        '{ROW_ITEM, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{ROW_CFG,  32'd0,         1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 32'd5,         1'b0, 1'b1, 32'd5},
        '{ROW_ITEM, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000},
        '{ROW_CFG,  32'd3,         1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 32'd10,        1'b1, 1'b0, 32'd0},
        '{ROW_ITEM, 32'd10,        1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 32'd10,        1'b0, 1'b1, 32'd10},
        '{ROW_ITEM, 32'd3,         1'b0, 1'b1, 32'd10},
        '{ROW_ITEM, 32'd2,         1'b0, 1'b1, 32'd10},
        '{ROW_ITEM, 32'd1,         1'b0, 1'b1, 32'd3},
        '{ROW_ITEM, 32'd1,         1'b1, 1'b0, 32'd0},
        '{ROW_CFG,  32'd2,         1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 32'd7,         1'b0, 1'b1, 32'd7},
        '{ROW_CFG,  32'd65,        1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 32'h8000_0000, 1'b1, 1'b0, 32'd0},
        '{ROW_CFG,  32'd127,       1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'd0},
        '{ROW_CFG,  32'd1,         1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000},
        '{ROW_CFG,  32'd4,         1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 32'd4,         1'b0, 1'b0, 32'd0}
    };

    // Block ports; every input holds a known value from time zero
    logic                i_clk             = 1'b0;
    logic                i_rst_n           = 1'b0;
    logic                i_cfg_valid       = 1'b0;
    logic [CFG_BITS-1:0] i_cfg_window_size = '0;
    logic                i_in_valid        = 1'b0;
    t_sample             i_sample          = '0;
    logic                i_start_req       = 1'b0;
    logic                i_out_ready       = 1'b0;
    logic                o_cfg_ready;
    logic                o_in_ready;
    logic                o_out_valid;
    t_sample             o_window_max;

    // Predictor state: window register, candidate deque, position and fill count
    logic [CFG_BITS-1:0] win_reg = CFG_BITS'(1);
    t_model_cand         cand_q[$];
    logic [POS_BITS-1:0] pos_ctr = '0;
    int                  seen_n  = 0;

    // Expected window maxima in transfer order, plus run bookkeeping
    t_sample pending_max_q[$];
    int      fail_count    = 0;
    int      items_sent    = 0;
    int      results_taken = 0;
    bit      send_burst    = 1'b0;

    sliding_window_maximum u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_window_size (i_cfg_window_size),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_sample          (i_sample),
        .i_start_req       (i_start_req),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_window_max      (o_window_max)
    );

    always #4 i_clk = ~i_clk;

    // Clamp the register to the window the block really uses: zero acts as one,
    // anything above the cell count acts as the cell count.
    function automatic int eff_window(input logic [CFG_BITS-1:0] r);
        if (r == '0) return 1;
        if (r > MAX_WINDOW) return MAX_WINDOW;
        return int'(r);
    endfunction

    // Advance the deque by one sample; return 1 when the sample yields a maximum.
    function automatic bit predict_window_max(input t_sample s, input logic start,
                                              output t_sample max_out);
        int                  w;
        logic [POS_BITS-1:0] age;
        t_model_cand         c;
        w = eff_window(win_reg);
        if (start) begin
            cand_q.delete();
            pos_ctr = '0;
            seen_n  = 0;
        end
        // drop front entries that have aged out; ages wrap with the position counter
        while (cand_q.size() > 0) begin
            age = pos_ctr - cand_q[0].pos;
            if (int'(age) < w) break;
            cand_q.delete(0);
        end
        // drop back entries that are not greater, so an equal older value goes too
        while (cand_q.size() > 0 && cand_q[$].value <= s)
            cand_q.delete(cand_q.size() - 1);
        c.value = s;
        c.pos   = pos_ctr;
        if (cand_q.size() < MAX_WINDOW) cand_q.insert(cand_q.size(), c);
        pos_ctr++;
        // clamp the fill count first, since the window may have shrunk since last sample
        if (seen_n > w) seen_n = w;
        if (seen_n < w) seen_n++;
        max_out = cand_q[0].value;
        return seen_n >= w;
    endfunction

    // Random sample: extremes, a narrow band for ties, a trend off the last one, or any value
    function automatic t_sample pick_sample(input int trend, input t_sample prev);
        t_sample v;
        case ($urandom_range(0, 9))
            0: v = t_sample'(32'h7FFF_FFFF);
            1: v = t_sample'(32'h8000_0000);
            2, 3: v = t_sample'($urandom_range(0, 6)) - t_sample'(3);
            default: begin
                if (trend == 1)      v = prev - t_sample'($urandom_range(0, 5));
                else if (trend == 2) v = prev + t_sample'($urandom_range(0, 5));
                else                 v = t_sample'($urandom);
            end
        endcase
        return v;
    endfunction

    // Hold the sender off until every expected maximum has been taken.
    // Always wait for a falling edge first so valid is never lowered and raised in one step.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_max_q.size() != 0);
    endtask

    // Write the window register once the block is idle. A sample with no result may
    // still be in the select tree, so let the pipeline settle before the write.
    task automatic write_window(input logic [CFG_BITS-1:0] w);
        wait_drained();
        repeat (8) @(negedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_window_size <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        win_reg = w;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one sample and record what it should produce once it is transferred.
    // Called at a falling edge; returns at the falling edge after the transfer with
    // valid still high, so a back-to-back call just swaps the payload.
    task automatic send_item(input t_sample s, input logic start, input logic known,
                             input t_sample known_max);
        int      gap;
        t_sample pred;
        bit      has_max;
        gap = send_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample    <= s;
        i_start_req <= start;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        has_max = predict_window_max(s, start, pred);
        if (known)        pending_max_q.insert(pending_max_q.size(), known_max);
        else if (has_max) pending_max_q.insert(pending_max_q.size(), pred);
        @(negedge i_clk);
    endtask

    // Compare every result transfer with the oldest pending maximum
    always @(posedge i_clk) begin : result_check
        t_sample want_max;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_taken++;
            if (pending_max_q.size() == 0) begin
                fail_count++;
                $display("%0t: window_max expected none, actual %0d", $time, o_window_max);
            end else begin
                want_max = pending_max_q[0];
                pending_max_q.delete(0);
                if (o_window_max !== want_max) begin
                    fail_count++;
                    $display("%0t: window_max expected %0d, actual %0d",
                             $time, want_max, o_window_max);
                end
            end
        end
    end

    // Result side: random stalls per transfer, quiet stretches with ready held high,
    // and now and then a long hold-off so the block fills up and stalls its input.
    initial begin : result_sink
        int gap;
        int next_hold;
        bit quiet;
        next_hold = 200;
        quiet     = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (results_taken >= next_hold) begin
                gap = $urandom_range(150, 250);
                next_hold += 700;
            end else begin
                gap = quiet ? 0 : $urandom_range(0, 11);
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
            if ($urandom_range(0, 39) == 0) quiet = !quiet;
        end
    end

    initial begin : stimulus
        int                  n_seq;
        int                  len;
        int                  trend;
        int                  pause_at;
        int                  eff;
        logic [CFG_BITS-1:0] w_val;
        t_sample             prev;
        logic                st;

        // hold reset low from time zero, then release it at a falling edge
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // walk the directed table
        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].kind == ROW_CFG)
                write_window(DIR_ROWS[i].data[CFG_BITS-1:0]);
            else
                send_item(t_sample'(DIR_ROWS[i].data), DIR_ROWS[i].start,
                          DIR_ROWS[i].known, t_sample'(DIR_ROWS[i].known_max));
        end

        // Random phases: pick a window (extremes and out-of-range values included),
        // then send well-formed sequences with random content. Some sequences are no
        // longer than the window, some run long enough to wrap the position counter,
        // and the first one of a phase may carry on the old sequence without a start.
        prev = '0;
        while (items_sent < 1750) begin
            case ($urandom_range(0, 9))
                0:       w_val = '0;
                1:       w_val = CFG_BITS'(1);
                2:       w_val = CFG_BITS'(MAX_WINDOW);
                3:       w_val = CFG_BITS'($urandom_range(MAX_WINDOW + 1, 127));
                4:       w_val = CFG_BITS'(2);
                5, 6, 7: w_val = CFG_BITS'($urandom_range(1, 8));
                8:       w_val = CFG_BITS'($urandom_range(9, 32));
                default: w_val = CFG_BITS'($urandom_range(33, MAX_WINDOW - 1));
            endcase
            write_window(w_val);
            eff   = eff_window(w_val);
            n_seq = $urandom_range(1, 4);
            for (int q = 0; q < n_seq; q++) begin
                trend      = $urandom_range(0, 2);
                send_burst = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 4) == 0)
                    len = $urandom_range(1, eff);
                else if ($urandom_range(0, 5) == 0)
                    len = eff + $urandom_range(100, 160);
                else
                    len = eff + $urandom_range(0, 40);
                // now and then pause mid-sequence until every result is in
                pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : -1;
                for (int k = 0; k < len; k++) begin
                    if (k == pause_at) wait_drained();
                    // a stray start inside a sequence breaks it off early
                    if (k == 0) st = !(q == 0 && $urandom_range(0, 3) == 0);
                    else        st = ($urandom_range(0, 63) == 0);
                    prev = pick_sample(trend, prev);
                    send_item(prev, st, 1'b0, '0);
                end
            end
        end
        send_burst = 1'b0;

        // drain, let the select tree settle, then report
        wait_drained();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Ceiling on the whole run, far above the slowest correct run
    initial begin : watchdog
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule
